// ===== src/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// Wildcard glob matcher package
// Request codes, wildcard characters and the sequencer microprogram.
// ----------------------------------------------------------------------------
package wgm_pkg;

  // Request kinds carried in the input tuser field.
  localparam logic [1:0] REQ_PAT  = 2'd0;
  localparam logic [1:0] REQ_NAME = 2'd1;
  localparam logic [1:0] REQ_EVAL = 2'd2;
  localparam logic [1:0] REQ_CLR  = 2'd3;

  // Wildcard characters.
  localparam logic [7:0] CHAR_ANY_ONE = 8'h3F;
  localparam logic [7:0] CHAR_ANY_RUN = 8'h2A;

  // Sequencer step codes.
  localparam logic [1:0] STEP_IDLE  = 2'd0;
  localparam logic [1:0] STEP_FETCH = 2'd1;
  localparam logic [1:0] STEP_TEST  = 2'd2;
  localparam logic [1:0] STEP_DONE  = 2'd3;

  // Datapath operations.
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_REQ  = 2'd1;
  localparam logic [1:0] OP_SCAN = 2'd2;
  localparam logic [1:0] OP_EMIT = 2'd3;

  // Jump conditions.
  localparam logic [1:0] JC_NEVER    = 2'd0;
  localparam logic [1:0] JC_EVAL     = 2'd1;
  localparam logic [1:0] JC_FINISH   = 2'd2;
  localparam logic [1:0] JC_OUT_FREE = 2'd3;

  // One control word per step.
  typedef struct packed {
    logic       accept;
    logic [1:0] op;
    logic [1:0] jcond;
    logic [1:0] target;
    logic [1:0] next;
  } ctl_t;

  // Microprogram read-only table.
  function automatic ctl_t wgm_rom(input logic [1:0] step);
    ctl_t w;
    unique case (step)
      STEP_IDLE:  w = '{accept: 1'b1, op: OP_REQ,  jcond: JC_EVAL,
                        target: STEP_FETCH, next: STEP_IDLE};
      STEP_FETCH: w = '{accept: 1'b0, op: OP_NONE, jcond: JC_NEVER,
                        target: STEP_IDLE, next: STEP_TEST};
      STEP_TEST:  w = '{accept: 1'b0, op: OP_SCAN, jcond: JC_FINISH,
                        target: STEP_DONE, next: STEP_FETCH};
      default:    w = '{accept: 1'b0, op: OP_EMIT, jcond: JC_OUT_FREE,
                        target: STEP_IDLE, next: STEP_DONE};
    endcase
    return w;
  endfunction

endpackage

// ===== src/wildcard_glob_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// Wildcard glob matcher unit
// Matches a stored name against a stored '?' / '*' pattern with a greedy
// scan that backtracks to the last star, run by a small microprogram.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one request per item: tuser selects append
//   pattern byte, append name byte, evaluate or clear pattern, and tdata
//   holds the byte for the appends. Only an evaluate produces a result on
//   the master stream: tdata bit 0 is matched, bit 1 is overflowed.
//   Appends and clear pattern complete in the step that accepts them. An
//   evaluate walks the backtracking scan from acceptance to the result
//   register; each scan step and the final check take a fetch and a test
//   step through the single read port of each store, and a done step then
//   loads the result. No new request is taken while an evaluate is in progress.
//   A byte that would exceed a store is dropped and sets a sticky overflow
//   flag; while it is set, evaluate reports no match. Clear pattern clears
//   the flag. Evaluate empties the name store.
//   Reset empties both stores and clears the flag; no clearing pass.
//   If the receiver stalls, the result stays in the output register and
//   loads are still accepted; a following evaluate waits for it to drain.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit #(
  parameter int MAX_PATTERN_LEN = 64,
  parameter int MAX_NAME_LEN    = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic [1:0] s_axis_tuser_i,   // [1:0] req_type
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] matched, [1] overflowed, [7:2] zero
);

  localparam int PLW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int NLW = $clog2(MAX_NAME_LEN + 1);
  localparam int PAW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int NAW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;

  // Stores and their read registers.
  logic [7:0] pat_mem [MAX_PATTERN_LEN];
  logic [7:0] name_mem [MAX_NAME_LEN];
  logic [7:0] pat_rd_q, name_rd_q;

  logic [1:0]     step_q, step_d;
  logic [PLW-1:0] pat_len_q, pat_len_d;
  logic [NLW-1:0] name_len_q, name_len_d;
  logic           ovf_q, ovf_d;
  logic [PLW-1:0] p_q, p_d, star_q, star_d;
  logic [NLW-1:0] n_q, n_d, resume_q, resume_d;
  logic           have_star_q, have_star_d;
  logic           hit_q, hit_d;
  logic           out_valid_q, out_valid_d;
  logic           out_match_q, out_match_d;
  logic           out_ovf_q, out_ovf_d;

  wgm_pkg::ctl_t ctl;
  logic          in_acc, is_eval, out_free, finish, jump;
  logic          pat_wr, name_wr;
  logic          p_in, n_in, c_eq, c_star;

  // Current control word.
  assign ctl = wgm_pkg::wgm_rom(step_q);

  assign s_axis_tready_o = ctl.accept;
  assign in_acc   = s_axis_tvalid_i && ctl.accept;
  assign is_eval  = in_acc && (s_axis_tuser_i == wgm_pkg::REQ_EVAL);
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign pat_wr  = in_acc && (s_axis_tuser_i == wgm_pkg::REQ_PAT) &&
                   (pat_len_q < PLW'(MAX_PATTERN_LEN));
  assign name_wr = in_acc && (s_axis_tuser_i == wgm_pkg::REQ_NAME) &&
                   (name_len_q < NLW'(MAX_NAME_LEN));

  // Scan step decisions on the registered store bytes.
  assign p_in   = p_q < pat_len_q;
  assign n_in   = n_q < name_len_q;
  assign c_eq   = (pat_rd_q == name_rd_q) || (pat_rd_q == wgm_pkg::CHAR_ANY_ONE);
  assign c_star = pat_rd_q == wgm_pkg::CHAR_ANY_RUN;
  assign finish = n_in ? !(p_in && (c_eq || c_star)) && !have_star_q
                       : !(p_in && c_star);

  // Jump selection.
  always_comb begin
    case (ctl.jcond)
      wgm_pkg::JC_EVAL:     jump = is_eval;
      wgm_pkg::JC_FINISH:   jump = finish;
      wgm_pkg::JC_OUT_FREE: jump = out_free;
      default:              jump = 1'b0;
    endcase
    step_d = jump ? ctl.target : ctl.next;
  end

  // Datapath driven by the control word.
  always_comb begin
    pat_len_d   = pat_len_q;
    name_len_d  = name_len_q;
    ovf_d       = ovf_q;
    p_d         = p_q;
    n_d         = n_q;
    star_d      = star_q;
    resume_d    = resume_q;
    have_star_d = have_star_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_match_d = out_match_q;
    out_ovf_d   = out_ovf_q;
    case (ctl.op)
      wgm_pkg::OP_REQ: begin
        if (in_acc) begin
          case (s_axis_tuser_i)
            wgm_pkg::REQ_PAT: begin
              if (pat_wr) pat_len_d = pat_len_q + PLW'(1);
              else        ovf_d = 1'b1;
            end
            wgm_pkg::REQ_NAME: begin
              if (name_wr) name_len_d = name_len_q + NLW'(1);
              else         ovf_d = 1'b1;
            end
            wgm_pkg::REQ_EVAL: begin
              p_d         = '0;
              n_d         = '0;
              star_d      = '0;
              resume_d    = '0;
              have_star_d = 1'b0;
            end
            default: begin
              pat_len_d = '0;
              ovf_d     = 1'b0;
            end
          endcase
        end
      end
      wgm_pkg::OP_SCAN: begin
        if (finish) begin
          hit_d = !n_in && (p_q == pat_len_q);
        end else if (n_in && p_in && c_eq) begin
          p_d = p_q + PLW'(1);
          n_d = n_q + NLW'(1);
        end else if (p_in && c_star) begin
          have_star_d = 1'b1;
          star_d      = p_q;
          resume_d    = n_q;
          p_d         = p_q + PLW'(1);
        end else begin
          // Backtrack: the last star absorbs one more name byte.
          p_d      = star_q + PLW'(1);
          resume_d = resume_q + NLW'(1);
          n_d      = resume_q + NLW'(1);
        end
      end
      wgm_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_match_d = hit_q && !ovf_q;
          out_ovf_d   = ovf_q;
          name_len_d  = '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= wgm_pkg::STEP_IDLE;
      pat_len_q   <= '0;
      name_len_q  <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      pat_len_q   <= pat_len_d;
      name_len_q  <= name_len_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Scan and result payload registers.
  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    n_q         <= n_d;
    star_q      <= star_d;
    resume_q    <= resume_d;
    have_star_q <= have_star_d;
    hit_q       <= hit_d;
    out_match_q <= out_match_d;
    out_ovf_q   <= out_ovf_d;
  end

  // Pattern store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (pat_wr) pat_mem[pat_len_q[PAW-1:0]] <= s_axis_tdata_i;
    pat_rd_q <= pat_mem[p_q[PAW-1:0]];
  end

  // Name store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (name_wr) name_mem[name_len_q[NAW-1:0]] <= s_axis_tdata_i;
    name_rd_q <= name_mem[n_q[NAW-1:0]];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_ovf_q, out_match_q};

`ifndef ASSERT_OFF
  // The scan never runs past the stored pattern.
  a_p_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == wgm_pkg::STEP_TEST) |-> (p_q <= pat_len_q))
    else $error("pattern index beyond pattern length");

  // The scan never runs past the stored name.
  a_n_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == wgm_pkg::STEP_TEST) |-> (n_q <= name_len_q))
    else $error("name index beyond name length");

  // An accepted evaluate starts the scan.
  a_eval_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_eval |=> (step_q == wgm_pkg::STEP_FETCH))
    else $error("evaluate did not start the scan");

  // Emitting a result empties the name store and shows the result.
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == wgm_pkg::STEP_DONE && out_free) |=>
      (name_len_q == '0 && out_valid_q && step_q == wgm_pkg::STEP_IDLE))
    else $error("result emit did not complete");

  // A reported match never comes with overflow.
  a_no_ovf_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_match_q && out_ovf_q))
    else $error("match reported with overflow");
`endif

endmodule

// ===== dv/wildcard_glob_matcher_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Wildcard glob matcher unit testbench
// Streams pattern, name, evaluate and clear requests into the matcher and
// checks every result against a cycle-free predictor of the store contents
// and the star/question-mark match. Covers directed corner cases, full and
// overflowing stores, a long output stall and random request sequences.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit_tb;

  localparam int STORE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 580;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 50;
  localparam int CYCLE_LIMIT  = 3000000;

  // Expected content of one result request.
  typedef struct packed {
    logic overflowed;
    logic matched;
  } verdict_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;            // [7:0] char_code
  logic [1:0] s_axis_tuser_i = wgm_pkg::REQ_PAT; // [1:0] req_type
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [0] matched, [1] overflowed, [7:2] zero

  // Shadow copy of the matcher state.
  logic [7:0] pat_mem [STORE_DEPTH];
  logic [7:0] name_mem [STORE_DEPTH];
  logic [6:0] pat_len = '0;
  logic [6:0] name_len = '0;
  logic       ovf_flag = 1'b0;

  verdict_t pending_verdicts [$];
  int       err_count = 0;
  int       items_sent = 0;
  int       cycle_count = 0;
  bit       tx_idle_on = 1'b0;
  bit       rx_idle_on = 1'b0;
  bit       hold_pending = 1'b0;

  wildcard_glob_matcher_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Idle lengths: mostly short, now and then long.
  function automatic int idle_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(16, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  // Byte drawn mostly from a small alphabet so that matches happen often.
  function automatic logic [7:0] glob_char();
    case ($urandom_range(0, 7))
      0, 1: return 8'h61;
      2: return 8'h62;
      3: return wgm_pkg::CHAR_ANY_ONE;
      4: return wgm_pkg::CHAR_ANY_RUN;
      5: return 8'h63;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Greedy wildcard scan over the shadow stores, backtracking to the last star.
  function automatic bit glob_hit();
    int p = 0;
    int n = 0;
    int star_p = 0;
    int resume = 0;
    bit seen_star = 1'b0;
    while (n < name_len) begin
      if (p < pat_len && (pat_mem[p] == name_mem[n] ||
                          pat_mem[p] == wgm_pkg::CHAR_ANY_ONE)) begin
        p++;
        n++;
      end else if (p < pat_len && pat_mem[p] == wgm_pkg::CHAR_ANY_RUN) begin
        seen_star = 1'b1;
        star_p = p;
        resume = n;
        p++;
      end else if (seen_star) begin
        p = star_p + 1;
        resume++;
        n = resume;
      end else begin
        return 1'b0;
      end
    end
    while (p < pat_len && pat_mem[p] == wgm_pkg::CHAR_ANY_RUN) begin
      p++;
    end
    return p == pat_len;
  endfunction

  // Update the shadow state for one accepted request; queue a result for evaluate.
  task automatic track_request(input logic [1:0] kind, input logic [7:0] ch);
    verdict_t v;
    case (kind)
      wgm_pkg::REQ_PAT: begin
        if (pat_len < STORE_DEPTH) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      wgm_pkg::REQ_NAME: begin
        if (name_len < STORE_DEPTH) begin
          name_mem[name_len] = ch;
          name_len++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      wgm_pkg::REQ_EVAL: begin
        v.matched = !ovf_flag && glob_hit();
        v.overflowed = ovf_flag;
        pending_verdicts = {pending_verdicts, v};
        name_len = '0;
      end
      default: begin
        pat_len = '0;
        ovf_flag = 1'b0;
      end
    endcase
  endtask

  // Offer one request and wait until it is taken. Valid stays high afterwards
  // so that back-to-back requests need no second assignment in one step.
  task automatic send_req(input logic [1:0] kind, input logic [7:0] ch);
    if (tx_idle_on && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (idle_gap()) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= ch;
    s_axis_tuser_i <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    track_request(kind, ch);
    items_sent++;
  endtask

  // Result receiver: random stalls, and one long hold-off on demand.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (idle_gap()) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Compare each delivered result with the oldest expected one.
  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_verdicts.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual tdata %02h",
                 $time, m_axis_tdata_o);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata_o[0] !== want.matched) begin
          err_count++;
          $display("%0t: matched mismatch, expected %0b, actual %0b",
                   $time, want.matched, m_axis_tdata_o[0]);
        end
        if (m_axis_tdata_o[1] !== want.overflowed) begin
          err_count++;
          $display("%0t: overflowed mismatch, expected %0b, actual %0b",
                   $time, want.overflowed, m_axis_tdata_o[1]);
        end
        if (m_axis_tdata_o[7:2] !== 6'b0) begin
          err_count++;
          $display("%0t: padding mismatch, expected 00, actual %02h",
                   $time, m_axis_tdata_o[7:2]);
        end
      end
    end
  end

  // Empty strings, byte extremes, wildcards and a backtracking case.
  task automatic test_directed();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    // Empty name against the empty pattern.
    send_req(wgm_pkg::REQ_EVAL, 8'hFF);
    // Empty name against a pattern of stars only.
    send_req(wgm_pkg::REQ_PAT, wgm_pkg::CHAR_ANY_RUN);
    send_req(wgm_pkg::REQ_PAT, wgm_pkg::CHAR_ANY_RUN);
    send_req(wgm_pkg::REQ_EVAL, 8'h00);
    // Extreme bytes swallowed by stars.
    send_req(wgm_pkg::REQ_NAME, 8'h00);
    send_req(wgm_pkg::REQ_NAME, 8'hFF);
    send_req(wgm_pkg::REQ_EVAL, 8'hA5);
    // Literal extremes around a single-byte wildcard.
    send_req(wgm_pkg::REQ_CLR, 8'hFF);
    send_req(wgm_pkg::REQ_PAT, 8'h00);
    send_req(wgm_pkg::REQ_PAT, wgm_pkg::CHAR_ANY_ONE);
    send_req(wgm_pkg::REQ_PAT, 8'hFF);
    send_req(wgm_pkg::REQ_NAME, 8'h00);
    send_req(wgm_pkg::REQ_NAME, 8'h41);
    send_req(wgm_pkg::REQ_NAME, 8'hFF);
    send_req(wgm_pkg::REQ_EVAL, 8'h00);
    // Name shorter than the pattern.
    send_req(wgm_pkg::REQ_NAME, 8'h00);
    send_req(wgm_pkg::REQ_NAME, 8'hFF);
    send_req(wgm_pkg::REQ_EVAL, 8'h00);
    // The star must absorb more than its first guess.
    send_req(wgm_pkg::REQ_CLR, 8'h00);
    send_req(wgm_pkg::REQ_PAT, 8'h61);
    send_req(wgm_pkg::REQ_PAT, wgm_pkg::CHAR_ANY_RUN);
    send_req(wgm_pkg::REQ_PAT, 8'h62);
    send_req(wgm_pkg::REQ_NAME, 8'h61);
    send_req(wgm_pkg::REQ_NAME, 8'h62);
    send_req(wgm_pkg::REQ_NAME, 8'h78);
    send_req(wgm_pkg::REQ_NAME, 8'h62);
    send_req(wgm_pkg::REQ_EVAL, 8'h00);
  endtask

  // Stores filled to the limit, one byte past it, and the sticky overflow.
  task automatic test_store_limits();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_req(wgm_pkg::REQ_CLR, 8'h00);
    send_req(wgm_pkg::REQ_PAT, wgm_pkg::CHAR_ANY_RUN);
    repeat (STORE_DEPTH) send_req(wgm_pkg::REQ_NAME, 8'($urandom_range(0, 255)));
    send_req(wgm_pkg::REQ_EVAL, 8'h00);
    repeat (STORE_DEPTH + 1) send_req(wgm_pkg::REQ_NAME, 8'($urandom_range(0, 255)));
    send_req(wgm_pkg::REQ_EVAL, 8'h00);
    // Evaluate leaves the flag set.
    send_req(wgm_pkg::REQ_EVAL, 8'h00);
    send_req(wgm_pkg::REQ_CLR, 8'h00);
    send_req(wgm_pkg::REQ_EVAL, 8'h00);
    repeat (STORE_DEPTH) send_req(wgm_pkg::REQ_PAT, wgm_pkg::CHAR_ANY_ONE);
    repeat (STORE_DEPTH) send_req(wgm_pkg::REQ_NAME, 8'($urandom_range(0, 255)));
    send_req(wgm_pkg::REQ_EVAL, 8'h00);
    send_req(wgm_pkg::REQ_PAT, 8'h61);
    send_req(wgm_pkg::REQ_EVAL, 8'h00);
    send_req(wgm_pkg::REQ_CLR, 8'h00);
  endtask

  // Receiver holds off while evaluates keep coming, so the input stalls.
  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_req(wgm_pkg::REQ_CLR, 8'h00);
    send_req(wgm_pkg::REQ_PAT, wgm_pkg::CHAR_ANY_RUN);
    send_req(wgm_pkg::REQ_PAT, 8'h62);
    hold_pending = 1'b1;
    repeat (5) begin
      repeat ($urandom_range(1, 4)) send_req(wgm_pkg::REQ_NAME, glob_char());
      send_req(wgm_pkg::REQ_NAME, 8'h62);
      send_req(wgm_pkg::REQ_EVAL, 8'h00);
    end
  endtask

  // Well-formed pattern/name/evaluate sequences with random content, plus
  // stray requests and sequences that skip the evaluate.
  task automatic test_random_sequences();
    logic [7:0] pat_chars [$];
    logic [7:0] c;
    int seq_no = 0;
    int start = items_sent;
    int len;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (seq_no % 8 == 0) begin
        tx_idle_on = $urandom_range(0, 2) != 0;
        rx_idle_on = $urandom_range(0, 2) != 0;
      end
      seq_no++;
      if ($urandom_range(0, 15) == 0) begin
        send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
      // New pattern most of the time; otherwise the old one is reused.
      if (pat_chars.size() == 0 || $urandom_range(0, 3) != 0) begin
        send_req(wgm_pkg::REQ_CLR, 8'($urandom_range(0, 255)));
        pat_chars = {};
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 8);
        repeat (len) begin
          c = glob_char();
          pat_chars = {pat_chars, c};
          send_req(wgm_pkg::REQ_PAT, c);
        end
      end
      // Name built from the pattern, with rare mutations, or fully random.
      if ($urandom_range(0, 2) != 0) begin
        foreach (pat_chars[i]) begin
          if (pat_chars[i] == wgm_pkg::CHAR_ANY_RUN) begin
            repeat ($urandom_range(0, 3)) send_req(wgm_pkg::REQ_NAME, glob_char());
          end else if (pat_chars[i] == wgm_pkg::CHAR_ANY_ONE ||
                       $urandom_range(0, 19) == 0) begin
            send_req(wgm_pkg::REQ_NAME, glob_char());
          end else begin
            send_req(wgm_pkg::REQ_NAME, pat_chars[i]);
          end
        end
      end else begin
        repeat ($urandom_range(0, 10)) send_req(wgm_pkg::REQ_NAME, glob_char());
      end
      if ($urandom_range(0, 9) != 0) begin
        send_req(wgm_pkg::REQ_EVAL, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_store_limits();
    test_output_backpressure();
    test_random_sequences();
    s_axis_tvalid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/wgm_pkg.sv
src/wildcard_glob_matcher_unit.sv
dv/wildcard_glob_matcher_unit_tb.sv
